@@ rtl/core/simon_pkg.sv @@
// shared constants, types and round functions for the simon 64/128 cipher
package simon_pkg;

   localparam int WORD_W    = 32;
   localparam int ROUNDS    = 44;
   localparam int KEY_WORDS = 4;
   localparam int RK_AW     = 6;
   localparam int CSR_AW    = 2;
   localparam int Z_LEN     = ROUNDS - KEY_WORDS;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [RK_AW-1:0]  rk_addr_type;

   localparam rk_addr_type LAST_ROUND = rk_addr_type'(ROUNDS - 1);

   // z3 sequence, bit i is z3[i]
   localparam logic [Z_LEN-1:0] Z3_SEQ = 40'b0001_0010_0000_0111_1010_0110_0011_0101_1101_1011;

   localparam word_type KEY_RESET [KEY_WORDS] = '{
      32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918
   };

   // status of the two engines as seen by the top level
   typedef struct packed {
      logic key_busy;
      logic cipher_busy;
   } simon_status_type;

   function automatic word_type rotl1(input word_type v);
      return {v[WORD_W-2:0], v[WORD_W-1]};
   endfunction

   function automatic word_type rotl2(input word_type v);
      return {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
   endfunction

   function automatic word_type rotl8(input word_type v);
      return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
   endfunction

   function automatic word_type rotr1(input word_type v);
      return {v[0], v[WORD_W-1:1]};
   endfunction

   function automatic word_type rotr3(input word_type v);
      return {v[2:0], v[WORD_W-1:3]};
   endfunction

   // feistel mixing function
   function automatic word_type round_f(input word_type v);
      return (rotl1(v) & rotl8(v)) ^ rotl2(v);
   endfunction

   // next round key from k[i-4], k[i-3], k[i-1] and z3 bit
   function automatic word_type key_next(input word_type k4, input word_type k3,
                                         input word_type k1, input logic zbit);
      word_type t;
      t = rotr3(k1) ^ k3;
      t = t ^ rotr1(t);
      return (~k4) ^ t ^ {{(WORD_W-1){1'b0}}, zbit} ^ word_type'(3);
   endfunction

endpackage

@@ rtl/core/simon_if.sv @@
// valid/ready channel interfaces for request and response beats
interface simon_req_if import simon_pkg::*;;
   logic     valid;
   logic     ready;
   logic     mode;
   word_type upper_word;
   word_type lower_word;

   modport source(output valid, output mode, output upper_word, output lower_word,
                  input ready);
   modport sink(input valid, input mode, input upper_word, input lower_word,
                output ready);
endinterface

interface simon_rsp_if import simon_pkg::*;;
   logic     valid;
   logic     ready;
   word_type result_upper;
   word_type result_lower;

   modport source(output valid, output result_upper, output result_lower, input ready);
   modport sink(input valid, input result_upper, input result_lower, output ready);
endinterface

@@ rtl/core/simon_key_sched.sv @@
// key word registers, round key expansion sequencer and round key memory
module simon_key_sched import simon_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  word_type          csr_wdata,
   input  rk_addr_type       rd_addr,
   output word_type          rd_data,
   output logic              busy
);

   word_type    key_ff  [KEY_WORDS];
   word_type    key_in  [KEY_WORDS];
   word_type    win_ff  [KEY_WORDS];
   word_type    win_in  [KEY_WORDS];
   logic        busy_ff, busy_in;
   rk_addr_type cnt_ff, cnt_in;
   word_type    wr_word;
   rk_addr_type z_idx;
   logic        zbit;
   word_type    mem [ROUNDS];
   word_type    rd_data_ff;

   always_comb begin
      for (int i = 0; i < KEY_WORDS; i++) begin
         key_in[i] = key_ff[i];
      end
      if (csr_we) begin
         key_in[csr_index] = csr_wdata;
      end
   end

   // z3 bit for round key cnt
   always_comb begin
      z_idx = cnt_ff - rk_addr_type'(KEY_WORDS);
      zbit  = (z_idx < rk_addr_type'(Z_LEN)) ? Z3_SEQ[z_idx] : 1'b0;
   end

   // first four entries are the key words, the rest come from the window
   always_comb begin
      if (cnt_ff < rk_addr_type'(KEY_WORDS)) begin
         wr_word = key_ff[cnt_ff[CSR_AW-1:0]];
      end else begin
         wr_word = key_next(win_ff[0], win_ff[1], win_ff[3], zbit);
      end
      for (int i = 0; i < KEY_WORDS - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[KEY_WORDS-1] = wr_word;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (csr_we) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == LAST_ROUND) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + rk_addr_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= KEY_RESET[i];
         end
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= key_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[cnt_ff] <= wr_word;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

@@ rtl/core/simon_cipher_core.sv @@
// round sequencer with one shared feistel round unit and result register
module simon_cipher_core import simon_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        start_mode,
   input  word_type    start_upper,
   input  word_type    start_lower,
   input  word_type    rk,
   output rk_addr_type rd_addr,
   output logic        busy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output word_type    res_upper,
   output word_type    res_lower
);

   logic        run_ff, run_in;
   rk_addr_type cnt_ff, cnt_in;
   logic        mode_ff;
   word_type    x_ff, y_ff;
   word_type    x_new, y_new;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    res_x_ff, res_y_ff;
   logic        last, commit, advance;
   rk_addr_type idx;
   word_type    a_word, b_word, r_word;

   assign last    = run_ff && (cnt_ff == LAST_ROUND);
   assign commit  = last && (!rsp_valid_ff || rsp_ready);
   assign advance = run_ff && (cnt_ff != LAST_ROUND);

   // key index one round ahead, held while the last round waits
   always_comb begin
      idx = advance ? (cnt_ff + rk_addr_type'(1)) : cnt_ff;
      if (start) begin
         rd_addr = start_mode ? LAST_ROUND : '0;
      end else begin
         rd_addr = mode_ff ? (LAST_ROUND - idx) : idx;
      end
   end

   // shared round unit: decrypt is the same round with halves swapped
   always_comb begin
      a_word = mode_ff ? y_ff : x_ff;
      b_word = mode_ff ? x_ff : y_ff;
      r_word = b_word ^ round_f(a_word) ^ rk;
      if (mode_ff) begin
         x_new = y_ff;
         y_new = r_word;
      end else begin
         x_new = r_word;
         y_new = x_ff;
      end
   end

   always_comb begin
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (advance) begin
         cnt_in = cnt_ff + rk_addr_type'(1);
      end else if (commit) begin
         run_in       = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mode_ff <= start_mode;
         x_ff    <= start_upper;
         y_ff    <= start_lower;
      end else if (advance) begin
         x_ff <= x_new;
         y_ff <= y_new;
      end
      if (commit) begin
         res_x_ff <= x_new;
         res_y_ff <= y_new;
      end
   end

   assign busy      = run_ff;
   assign rsp_valid = rsp_valid_ff;
   assign res_upper = res_x_ff;
   assign res_lower = res_y_ff;

endmodule

@@ rtl/core/simon64_128_block_cipher.sv @@
// simon 64/128 block cipher top level
// Encrypts or decrypts one 64-bit block per request beat (mode 0 encrypt,
// mode 1 decrypt) with the 128-bit key held in four 32-bit key word registers.
// One feistel round unit is reused for all 44 rounds, one round per cycle, with
// round keys read from a 44-entry round key memory; the last round waits while
// an earlier result is untaken. A request is taken only after the previous
// block's rounds; the response register lets it start while a result waits.
// After reset and after every key word write the key schedule rewrites the
// memory, one round key per cycle; req.ready stays low during that pass. Key
// words should be written only while the block is idle.
module simon64_128_block_cipher import simon_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  word_type          csr_wdata,
   simon_req_if.sink         req,
   simon_rsp_if.source       rsp
);

   simon_status_type status;
   logic             start;
   rk_addr_type      rd_addr;
   word_type         rk;

   // new beat only when both the key schedule and the round engine are idle
   assign req.ready = !status.key_busy && !status.cipher_busy;
   assign start     = req.valid && req.ready;

   // key words, expansion pass and round key memory
   simon_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_addr   (rd_addr),
      .rd_data   (rk),
      .busy      (status.key_busy)
   );

   // round engine and response register
   simon_cipher_core u_cipher_core (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_mode  (req.mode),
      .start_upper (req.upper_word),
      .start_lower (req.lower_word),
      .rk          (rk),
      .rd_addr     (rd_addr),
      .busy        (status.cipher_busy),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .res_upper   (rsp.result_upper),
      .res_lower   (rsp.result_lower)
   );

endmodule

@@ tb/simon_checker.sv @@
// scoreboard for the simon 64/128 cipher: predicts each request beat and checks each response beat
`timescale 1ns / 1ps

module simon_checker import simon_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  word_type          csr_wdata,
   simon_req_if              req_mon,
   simon_rsp_if              rsp_mon,
   output int                fail_count,
   output int                pending
);

   // z3 constant sequence, bit i is z3[i]
   localparam logic [Z_LEN-1:0] Z3_BITS = 40'h12_07a6_35db;
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      word_type upper;
      word_type lower;
   } block_type;

   word_type  key_reg [KEY_WORDS];
   word_type  sched [ROUNDS];
   block_type cipher_q [$];
   int        mismatches;

   function automatic word_type rol(input word_type v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

   function automatic word_type ror(input word_type v, input int s);
      return (v >> s) | (v << (WORD_W - s));
   endfunction

   function automatic word_type mix(input word_type v);
      return (rol(v, 1) & rol(v, 8)) ^ rol(v, 2);
   endfunction

   // rebuild all 44 round keys from the current key words
   function automatic void expand_schedule();
      word_type t;
      for (int i = 0; i < KEY_WORDS; i++)
         sched[i] = key_reg[i];
      for (int i = KEY_WORDS; i < ROUNDS; i++) begin
         t = ror(sched[i-1], 3) ^ sched[i-3];
         t = t ^ ror(t, 1);
         sched[i] = ~sched[i-4] ^ t ^ word_type'(Z3_BITS[i-KEY_WORDS]) ^ word_type'(3);
      end
   endfunction

   function automatic block_type cipher_block(input logic decrypt, input word_type x_in,
                                              input word_type y_in);
      word_type x;
      word_type y;
      word_type t;
      x = x_in;
      y = y_in;
      for (int i = 0; i < ROUNDS; i++) begin
         if (!decrypt) begin
            t = x;
            x = y ^ mix(x) ^ sched[i];
            y = t;
         end else begin
            t = y;
            y = x ^ mix(y) ^ sched[ROUNDS-1-i];
            x = t;
         end
      end
      return '{upper: x, lower: y};
   endfunction

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      if (mismatches < MAX_PRINTED)
         $display("%0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      block_type want;
      if (reset) begin
         key_reg = '{32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918};
         expand_schedule();
         cipher_q.delete();
         mismatches = 0;
      end else begin
         // a key word write takes effect for the next block
         if (csr_we && csr_index < KEY_WORDS) begin
            key_reg[csr_index] = csr_wdata;
            expand_schedule();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (cipher_q.size() == 0) begin
               report_mismatch("response with no block in flight, upper", rsp_mon.result_upper,
                               '0);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_mon.result_upper !== want.upper)
                  report_mismatch("result_upper", rsp_mon.result_upper, want.upper);
               if (rsp_mon.result_lower !== want.lower)
                  report_mismatch("result_lower", rsp_mon.result_lower, want.lower);
            end
         end
         if (req_mon.valid && req_mon.ready)
            cipher_q.push_back(cipher_block(req_mon.mode, req_mon.upper_word,
                                            req_mon.lower_word));
      end
      pending    <= cipher_q.size();
      fail_count <= mismatches;
   end

endmodule

@@ tb/testbench.sv @@
// top of the simon 64/128 cipher testbench: clock, reset, key writes, block stimulus and verdict
`timescale 1ns / 1ps

module testbench import simon_pkg::*;;

   localparam int CLK_PERIOD      = 20;
   localparam int HALF_PERIOD     = CLK_PERIOD / 2;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 60;     // quiet stretch longer than one block
   localparam int HOLD_CYCLES     = 300;    // long response stall that backs up the block
   localparam int MAX_GAP         = 19;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int LIMIT_CYCLES    = 800000;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [KEY_WORDS-1:0] ALL_KEY_WORDS = '1;
   localparam logic [KEY_WORDS-1:0] ONLY_WORD_2   = 4'b0100;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_index;
   word_type          csr_wdata;

   simon_req_if req_bus ();
   simon_rsp_if rsp_bus ();

   int       fail_count;
   int       pending;
   bit       steady;          // both sides drop their random gaps
   bit       hold_request;    // asks the receiver for one long stall
   word_type next_key [KEY_WORDS];

   simon64_128_block_cipher uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .rsp       (rsp_bus)
   );

   simon_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // free running clock
   initial clock = 1'b0;
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // idle cycles before the next beat on either side
   function automatic int pick_gap();
      if (steady)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // mostly random words, with all zeros, all ones and single bits mixed in
   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, WORD_W - 1);
         default: return word_type'($urandom);
      endcase
   endfunction

   // offer one block after its gap and hold it until the block takes it;
   // valid is only lowered when a gap follows, so back-to-back beats keep it high
   task automatic send_block(input logic mode, input word_type x, input word_type y);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.upper_word <= x;
      req_bus.lower_word <= y;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // stop offering, let every result come back, then give the block time to settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the selected key words back to back from next_key, only while idle
   task automatic load_keys(input logic [KEY_WORDS-1:0] which);
      for (int i = 0; i < KEY_WORDS; i++) begin
         if (which[i]) begin
            csr_we    <= 1'b1;
            csr_index <= i[CSR_AW-1:0];
            csr_wdata <= next_key[i];
            @(posedge clock);
         end
      end
      csr_we <= 1'b0;
   endtask

   // response side: random stall per beat, one long hold-off when asked
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         stall = pick_gap();
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // request side and verdict
   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_ENCRYPT;
      req_bus.upper_word <= '0;
      req_bus.lower_word <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed blocks under the reset key; the block holds ready low during
      // its key pass, so the first beat simply waits
      send_block(MODE_ENCRYPT, 32'h656b_696c, 32'h2064_6e75);   // published test vector
      send_block(MODE_DECRYPT, 32'h44c8_fc20, 32'hb9df_a07a);   // and its ciphertext back
      send_block(MODE_ENCRYPT, '0, '0);
      send_block(MODE_DECRYPT, '0, '0);
      send_block(MODE_ENCRYPT, '1, '1);
      send_block(MODE_DECRYPT, '1, '1);
      send_block(MODE_ENCRYPT, '1, '0);
      send_block(MODE_DECRYPT, '0, '1);
      send_block(MODE_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
      send_block(MODE_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
      send_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      wait_idle();

      // random phases, each under its own key; keys change only once drained
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;                                   // keep the reset key
            1: begin
               next_key = '{default: '0};
               load_keys(ALL_KEY_WORDS);
            end
            2: begin
               next_key = '{default: '1};
               load_keys(ALL_KEY_WORDS);
            end
            3: begin
               // one word alone, the others stay as they were
               next_key[2] = word_type'($urandom);
               load_keys(ONLY_WORD_2);
            end
            5: begin
               next_key = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
               load_keys(ALL_KEY_WORDS);
            end
            default: begin
               for (int k = 0; k < KEY_WORDS; k++)
                  next_key[k] = pick_word();
               load_keys(ALL_KEY_WORDS);
            end
         endcase

         // back-to-back stretches; two of them also stall the response side
         // for a long time while requests keep coming
         steady       = (phase == 2) || (phase % 5 == 4);
         hold_request = (phase == 2) || (phase == 9);

         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_block($urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT,
                       pick_word(), pick_word());

         // sender pauses here until every result is back
         wait_idle();
         steady = 1'b0;
      end

      if (fail_count == 0)
         $display("simon64_128_block_cipher verification clean");
      else
         $display("simon64_128_block_cipher verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("simon64_128_block_cipher verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/simon_pkg.sv
rtl/core/simon_if.sv
rtl/core/simon_key_sched.sv
rtl/core/simon_cipher_core.sv
rtl/core/simon64_128_block_cipher.sv
tb/simon_checker.sv
tb/testbench.sv
